// File: hw/rtl/cxalu_pkg.sv
package cxalu_pkg;

	localparam int DW  = 32;        // operand and result width
	localparam int FB  = 16;        // fraction bits
	localparam int OPW = 3;         // opcode width
	localparam int PW  = 2 * DW;    // full product width
	localparam int RW  = 3 * DW;    // divider remainder width

	localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [OPW-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_NEG = 3'd4,
		OP_MAG = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		K_ADD,
		K_SUB,
		K_MUL,
		K_DIV,
		K_NEG,
		K_MAG,
		K_NONE
	} kind_t;

	typedef struct packed {
		kind_t         kind;
		logic [DW-1:0] ar;
		logic [DW-1:0] ai;
		logic [DW-1:0] br;
		logic [DW-1:0] bi;
	} item_t;

endpackage

// File: hw/rtl/complex_number_alu_unit.sv
// Complex arithmetic unit, signed Q16.16 operands and results.
// Command channel: drive op, a_real, a_imag, b_real, b_imag with start; the
// word is taken at a rising edge where start is high and busy is low.
// Ops: add, subtract, multiply, divide, negate, magnitude (result in the real
// part, imaginary part 0). Codes 6 and 7 return zero with no flags.
// Result channel: done is high for one cycle with res_real, res_imag,
// overflow and divide_by_zero; there is no back-pressure, take it then.
// From the accepting edge to the result, a word passes the input register,
// queue, multiplier stage, cross-sum stage, prep stage, 33 restoring
// divide / square-root stages (one quotient bit each), output register.
// Every op goes through the same stages, so results come out in order.
// Throughput: one word per cycle; the front register and a 2-deep queue
// feed a back pipeline that never stalls, so busy stays low in normal use.
// Reset clears all valid bits; no result is produced for anything in flight.
module complex_number_alu_unit import cxalu_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  logic [OPW-1:0] op,
	input  logic [DW-1:0]  a_real,
	input  logic [DW-1:0]  a_imag,
	input  logic [DW-1:0]  b_real,
	input  logic [DW-1:0]  b_imag,
	output logic           done,
	output logic [DW-1:0]  res_real,
	output logic [DW-1:0]  res_imag,
	output logic           overflow,
	output logic           divide_by_zero
);

	localparam int LAT = DW + 7;

	logic  v_s1;
	item_t item_s1;
	logic  q_full;
	logic  q_v;
	item_t q_item;

	cxalu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.op      (op),
		.a_real  (a_real),
		.a_imag  (a_imag),
		.b_real  (b_real),
		.b_imag  (b_imag),
		.q_full  (q_full),
		.busy    (busy),
		.v_s1    (v_s1),
		.item_s1 (item_s1)
	);

	cxalu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (v_s1 & ~q_full),
		.din    (item_s1),
		.full   (q_full),
		.ovld   (q_v),
		.dout   (q_item)
	);

	cxalu_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_v           (q_v),
		.in_item        (q_item),
		.done           (done),
		.res_real       (res_real),
		.res_imag       (res_imag),
		.overflow       (overflow),
		.divide_by_zero (divide_by_zero)
	);

	a_dz_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_by_zero |-> overflow &&
		(res_real == SMAX || res_real == SMIN) && (res_imag == SMAX || res_imag == SMIN))
		else $error("divide by zero without saturated result");

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("accepted word gave no result on time");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching command");

endmodule

// File: hw/rtl/cxalu_front.sv
module cxalu_front import cxalu_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [OPW-1:0] op,
	input  logic [DW-1:0]  a_real,
	input  logic [DW-1:0]  a_imag,
	input  logic [DW-1:0]  b_real,
	input  logic [DW-1:0]  b_imag,
	input  logic           q_full,
	output logic           busy,
	output logic           v_s1,
	output item_t          item_s1
);

	logic  accept;
	kind_t kind;

	assign busy   = v_s1 & q_full;
	assign accept = start & ~busy;

	always_comb begin
		unique case (op)
			OP_ADD:  kind = K_ADD;
			OP_SUB:  kind = K_SUB;
			OP_MUL:  kind = K_MUL;
			OP_DIV:  kind = K_DIV;
			OP_NEG:  kind = K_NEG;
			OP_MAG:  kind = K_MAG;
			default: kind = K_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept | (v_s1 & q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{kind: kind, ar: a_real, ai: a_imag, br: b_real, bi: b_imag};
		end
	end

endmodule

// File: hw/rtl/cxalu_queue.sv
module cxalu_queue import cxalu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t din,
	output logic  full,
	output logic  ovld,
	output item_t dout
);

	localparam int QD  = 2;
	localparam int QAW = $clog2(QD);

	item_t          mem_q [QD];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           pop;

	// back end never stalls: a waiting word leaves every cycle
	assign pop  = ovld;
	assign full = (cnt_q == (QAW+1)'(QD));
	assign ovld = (cnt_q != '0);
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

endmodule

// File: hw/rtl/cxalu_back.sv
module cxalu_back import cxalu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_v,
	input  item_t         in_item,
	output logic          done,
	output logic [DW-1:0] res_real,
	output logic [DW-1:0] res_imag,
	output logic          overflow,
	output logic          divide_by_zero
);

	localparam int NS = DW + 1;     // quotient bits incl. the too-big bit

	// {ovf, value}; big means magnitude >= 2**DW
	function automatic logic [DW:0] sat_mag(input logic big, input logic [DW-1:0] m,
			input logic neg);
		logic [DW:0] r;
		if (!neg && (big || m[DW-1])) begin
			r = {1'b1, SMAX};
		end else if (neg && (big || (m[DW-1] && (|m[DW-2:0])))) begin
			r = {1'b1, SMIN};
		end else begin
			r = {1'b0, neg ? (~m + 1'b1) : m};
		end
		return r;
	endfunction

	function automatic logic [DW:0] sat_sum(input logic [DW:0] v);
		logic [DW:0] r;
		if (v[DW] != v[DW-1]) begin
			r = {1'b1, v[DW] ? SMIN : SMAX};
		end else begin
			r = {1'b0, v[DW-1:0]};
		end
		return r;
	endfunction

	// ---- products
	logic                 v_s2;
	kind_t                kind_s2;
	logic [DW-1:0]        ar_s2, ai_s2, br_s2, bi_s2;
	logic signed [PW-1:0] prr_s2, pii_s2, pri_s2, pir_s2, sq0_s2, sq1_s2;
	logic [DW-1:0]        x0, x1;

	assign x0 = (in_item.kind == K_MAG) ? in_item.ar : in_item.br;
	assign x1 = (in_item.kind == K_MAG) ? in_item.ai : in_item.bi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2 <= in_item.kind;
		ar_s2   <= in_item.ar;
		ai_s2   <= in_item.ai;
		br_s2   <= in_item.br;
		bi_s2   <= in_item.bi;
		prr_s2  <= $signed(in_item.ar) * $signed(in_item.br);
		pii_s2  <= $signed(in_item.ai) * $signed(in_item.bi);
		pri_s2  <= $signed(in_item.ar) * $signed(in_item.bi);
		pir_s2  <= $signed(in_item.ai) * $signed(in_item.br);
		sq0_s2  <= $signed(x0) * $signed(x0);
		sq1_s2  <= $signed(x1) * $signed(x1);
	end

	// ---- cross sums, simple ops
	logic                 v_s3;
	kind_t                kind_s3;
	logic                 sar_s3, sai_s3;
	logic signed [PW:0]   re_s3, im_s3;
	logic [PW-1:0]        sq_s3;
	logic [DW:0]          sre_s3, sim_s3;
	logic signed [PW:0]   e_rr, e_ii, e_ri, e_ir, re_c, im_c;
	logic [DW:0]          sre_c, sim_c;
	logic [DW:0]          ar_e, ai_e, br_e, bi_e;

	always_comb begin
		e_rr = (PW+1)'(prr_s2);
		e_ii = (PW+1)'(pii_s2);
		e_ri = (PW+1)'(pri_s2);
		e_ir = (PW+1)'(pir_s2);
		if (kind_s2 == K_DIV) begin
			re_c = e_rr + e_ii;
			im_c = e_ir - e_ri;
		end else begin
			re_c = e_rr - e_ii;
			im_c = e_ri + e_ir;
		end
		ar_e = {ar_s2[DW-1], ar_s2};
		ai_e = {ai_s2[DW-1], ai_s2};
		br_e = {br_s2[DW-1], br_s2};
		bi_e = {bi_s2[DW-1], bi_s2};
		unique case (kind_s2)
			K_ADD: begin
				sre_c = sat_sum(ar_e + br_e);
				sim_c = sat_sum(ai_e + bi_e);
			end
			K_SUB: begin
				sre_c = sat_sum(ar_e - br_e);
				sim_c = sat_sum(ai_e - bi_e);
			end
			K_NEG: begin
				sre_c = sat_sum('0 - ar_e);
				sim_c = sat_sum('0 - ai_e);
			end
			default: begin
				sre_c = '0;
				sim_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		kind_s3 <= kind_s2;
		sar_s3  <= ar_s2[DW-1];
		sai_s3  <= ai_s2[DW-1];
		re_s3   <= re_c;
		im_s3   <= im_c;
		sq_s3   <= PW'(sq0_s2 + sq1_s2);
		sre_s3  <= sre_c;
		sim_s3  <= sim_c;
	end

	// ---- iteration stages; index 0 is the prep stage
	logic          v_sk     [0:NS];
	kind_t         kind_sk  [0:NS];
	logic [DW-1:0] sres_re_sk [0:NS];
	logic [DW-1:0] sres_im_sk [0:NS];
	logic          sovf_sk  [0:NS];
	logic          dz_sk    [0:NS];
	logic          nre_sk   [0:NS];
	logic          nim_sk   [0:NS];
	logic [RW-1:0] rre_sk   [0:NS];
	logic [RW-1:0] rim_sk   [0:NS];
	logic [DW:0]   qre_sk   [0:NS];
	logic [DW:0]   qim_sk   [0:NS];
	logic [PW-1:0] den_sk   [0:NS];
	logic [PW:0]   srem_sk  [0:NS];
	logic [DW-1:0] root_sk  [0:NS];

	logic [PW:0]      mre, mim, shre, shim;
	logic [DW:0]      mulre, mulim;
	logic             dz0;
	logic [DW-1:0]    p_re, p_im;
	logic             p_ovf;

	always_comb begin
		mre   = re_s3[PW] ? (PW+1)'(-re_s3) : (PW+1)'(re_s3);
		mim   = im_s3[PW] ? (PW+1)'(-im_s3) : (PW+1)'(im_s3);
		shre  = mre >> FB;
		shim  = mim >> FB;
		mulre = sat_mag(|shre[PW:DW], shre[DW-1:0], re_s3[PW]);
		mulim = sat_mag(|shim[PW:DW], shim[DW-1:0], im_s3[PW]);
		dz0   = (kind_s3 == K_DIV) && (sq_s3 == '0);
		if (kind_s3 == K_MUL) begin
			p_re  = mulre[DW-1:0];
			p_im  = mulim[DW-1:0];
			p_ovf = mulre[DW] | mulim[DW];
		end else if (dz0) begin
			p_re  = sar_s3 ? SMIN : SMAX;
			p_im  = sai_s3 ? SMIN : SMAX;
			p_ovf = 1'b1;
		end else begin
			p_re  = sre_s3[DW-1:0];
			p_im  = sim_s3[DW-1:0];
			p_ovf = sre_s3[DW] | sim_s3[DW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sk[0] <= 1'b0;
		end else begin
			v_sk[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		kind_sk[0]    <= kind_s3;
		sres_re_sk[0] <= p_re;
		sres_im_sk[0] <= p_im;
		sovf_sk[0]    <= p_ovf;
		dz_sk[0]      <= dz0;
		nre_sk[0]     <= re_s3[PW];
		nim_sk[0]     <= im_s3[PW];
		rre_sk[0]     <= RW'(mre) << FB;
		rim_sk[0]     <= RW'(mim) << FB;
		qre_sk[0]     <= '0;
		qim_sk[0]     <= '0;
		den_sk[0]     <= sq_s3;
		srem_sk[0]    <= (PW+1)'(sq_s3);
		root_sk[0]    <= '0;
	end

	for (genvar j = 0; j < NS; j++) begin : g_it
		localparam int B = DW - j;
		logic [RW-1:0] tdv;
		logic          gre, gim;
		logic [DW:0]   qre_n, qim_n;
		logic [PW:0]   srem_n;
		logic [DW-1:0] root_n;

		assign tdv = RW'(den_sk[j]) << B;
		assign gre = (rre_sk[j] >= tdv);
		assign gim = (rim_sk[j] >= tdv);

		always_comb begin
			qre_n    = qre_sk[j];
			qim_n    = qim_sk[j];
			qre_n[B] = gre;
			qim_n[B] = gim;
		end

		if (B < DW) begin : g_sq
			logic [PW:0] tsq;
			logic        gs;
			assign tsq = ((PW+1)'(root_sk[j]) << (B + 1)) + ((PW+1)'(1) << (2 * B));
			assign gs  = (srem_sk[j] >= tsq);
			always_comb begin
				root_n    = root_sk[j];
				root_n[B] = gs;
				srem_n    = gs ? (srem_sk[j] - tsq) : srem_sk[j];
			end
		end else begin : g_nosq
			assign root_n = root_sk[j];
			assign srem_n = srem_sk[j];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[j+1] <= 1'b0;
			end else begin
				v_sk[j+1] <= v_sk[j];
			end
		end

		always_ff @(posedge clk) begin
			kind_sk[j+1]    <= kind_sk[j];
			sres_re_sk[j+1] <= sres_re_sk[j];
			sres_im_sk[j+1] <= sres_im_sk[j];
			sovf_sk[j+1]    <= sovf_sk[j];
			dz_sk[j+1]      <= dz_sk[j];
			nre_sk[j+1]     <= nre_sk[j];
			nim_sk[j+1]     <= nim_sk[j];
			rre_sk[j+1]     <= gre ? (rre_sk[j] - tdv) : rre_sk[j];
			rim_sk[j+1]     <= gim ? (rim_sk[j] - tdv) : rim_sk[j];
			qre_sk[j+1]     <= qre_n;
			qim_sk[j+1]     <= qim_n;
			den_sk[j+1]     <= den_sk[j];
			srem_sk[j+1]    <= srem_n;
			root_sk[j+1]    <= root_n;
		end
	end

	// ---- result select and output register
	logic [DW:0]   dre, dim, mag;
	logic [DW-1:0] f_re, f_im;
	logic          f_ovf;

	always_comb begin
		dre = sat_mag(qre_sk[NS][DW], qre_sk[NS][DW-1:0], nre_sk[NS]);
		dim = sat_mag(qim_sk[NS][DW], qim_sk[NS][DW-1:0], nim_sk[NS]);
		mag = sat_mag(1'b0, root_sk[NS], 1'b0);
		if (kind_sk[NS] == K_DIV && !dz_sk[NS]) begin
			f_re  = dre[DW-1:0];
			f_im  = dim[DW-1:0];
			f_ovf = dre[DW] | dim[DW];
		end else if (kind_sk[NS] == K_MAG) begin
			f_re  = mag[DW-1:0];
			f_im  = '0;
			f_ovf = mag[DW];
		end else begin
			f_re  = sres_re_sk[NS];
			f_im  = sres_im_sk[NS];
			f_ovf = sovf_sk[NS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_sk[NS];
		end
	end

	always_ff @(posedge clk) begin
		res_real       <= f_re;
		res_imag       <= f_im;
		overflow       <= f_ovf;
		divide_by_zero <= dz_sk[NS];
	end

endmodule
